// ===== rtl/core/rtp_pkg.sv =====
package rtp_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int QUAT_WIDTH  = 16;
   localparam int QFRAC       = QUAT_WIDTH - 2;
   localparam int MAT_FRAC    = 2 * QFRAC;
   localparam int MAT_WIDTH   = 2 * QFRAC + 4;
   localparam int VEC_WIDTH   = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = MAT_WIDTH + VEC_WIDTH;
   localparam int ACC_WIDTH   = PROD_WIDTH + 3;
   localparam int SH_WIDTH    = ACC_WIDTH - MAT_FRAC;

   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = (COORD_WIDTH > QUAT_WIDTH) ? COORD_WIDTH : QUAT_WIDTH;

   typedef enum logic [1:0] {
      CMD_POINT      = 2'd0,
      CMD_VECTOR     = 2'd1,
      CMD_INV_POINT  = 2'd2,
      CMD_INV_VECTOR = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_POS_X = 3'd0,
      CSR_POS_Y = 3'd1,
      CSR_POS_Z = 3'd2,
      CSR_ROT_X = 3'd3,
      CSR_ROT_Y = 3'd4,
      CSR_ROT_Z = 3'd5,
      CSR_ROT_W = 3'd6
   } csr_idx_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [QUAT_WIDTH-1:0]  quat_comp_type;
   typedef logic signed [MAT_WIDTH-1:0]   mat_elem_type;

   typedef struct packed {
      cmd_type   command;
      coord_type coord_x;
      coord_type coord_y;
      coord_type coord_z;
   } req_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      coord_type out_z;
   } rsp_type;

endpackage

// ===== rtl/core/rtp_quat_norm.sv =====
module rtp_quat_norm import rtp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  quat_comp_type rot [4],
   output logic          busy,
   output mat_elem_type  mat [3][3]
);

   localparam int SMAG_WIDTH  = 30;
   localparam int LEN_WIDTH   = $clog2(QUAT_WIDTH + 1);
   localparam int EXT_WIDTH   = SMAG_WIDTH + QUAT_WIDTH;
   localparam int NSQ_WIDTH   = 2 * SMAG_WIDTH + 2;
   localparam int RACC_WIDTH  = NSQ_WIDTH + 1;
   localparam int ROOT_ITER   = NSQ_WIDTH / 2;
   localparam int RCNT_WIDTH  = $clog2(ROOT_ITER);
   localparam int ROOT_WIDTH  = SMAG_WIDTH + 1;
   localparam int DIV_WIDTH   = SMAG_WIDTH + QFRAC + 2;
   localparam int QBIT_WIDTH  = $clog2(QFRAC + 1);
   localparam int PQ_WIDTH    = 2 * QUAT_WIDTH;
   localparam int SUM_WIDTH   = PQ_WIDTH + 2;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SCALE   = 7'b0000010,
      ST_SQUARE  = 7'b0000100,
      ST_ROOT    = 7'b0001000,
      ST_DIVIDE  = 7'b0010000,
      ST_PRODUCT = 7'b0100000,
      ST_MATRIX  = 7'b1000000
   } norm_state_type;

   norm_state_type state_ff, state_in;
   logic                          neg_ff [4], neg_in [4];
   logic [SMAG_WIDTH-1:0]         smag_ff [4], smag_in [4];
   logic [1:0]                    sq_cnt_ff, sq_cnt_in;
   logic [NSQ_WIDTH-1:0]          nsq_ff, nsq_in;
   logic [NSQ_WIDTH-1:0]          rrem_ff, rrem_in;
   logic [RACC_WIDTH-1:0]         root_ff, root_in;
   logic [RCNT_WIDTH-1:0]         root_cnt_ff, root_cnt_in;
   logic [ROOT_WIDTH-1:0]         nrm_ff, nrm_in;
   logic [DIV_WIDTH-1:0]          drem_ff, drem_in;
   logic [QUAT_WIDTH-1:0]         quo_ff, quo_in;
   logic [QBIT_WIDTH-1:0]         div_bit_ff, div_bit_in;
   logic [1:0]                    comp_ff, comp_in;
   quat_comp_type                 qn_ff [4], qn_in [4];
   logic signed [PQ_WIDTH-1:0]    pq_ff [10], pq_in [10];
   mat_elem_type                  mat_ff [3][3], mat_in [3][3];

   logic [QUAT_WIDTH-1:0]         mag [4];
   logic [QUAT_WIDTH-1:0]         mag_or;
   logic [LEN_WIDTH-1:0]          len;
   logic [EXT_WIDTH-1:0]          mag_ext;
   logic [NSQ_WIDTH-1:0]          sq_term;
   logic [RACC_WIDTH-1:0]         rbit, rsum, root_nx;
   logic [NSQ_WIDTH-1:0]          rrem_nx;
   logic [DIV_WIDTH-1:0]          dsub, drem_nx;
   logic [QUAT_WIDTH-1:0]         quo_nx;
   logic                          dge;
   logic signed [SUM_WIDTH-1:0]   e [10];

   function automatic logic [DIV_WIDTH-1:0] div_init(input logic [SMAG_WIDTH-1:0] s,
                                                      input logic [ROOT_WIDTH-1:0] n);
      return (DIV_WIDTH'(s) << QFRAC) + DIV_WIDTH'(n >> 1);
   endfunction

   always_comb begin
      state_in    = state_ff;
      neg_in      = neg_ff;
      smag_in     = smag_ff;
      sq_cnt_in   = sq_cnt_ff;
      nsq_in      = nsq_ff;
      rrem_in     = rrem_ff;
      root_in     = root_ff;
      root_cnt_in = root_cnt_ff;
      nrm_in      = nrm_ff;
      drem_in     = drem_ff;
      quo_in      = quo_ff;
      div_bit_in  = div_bit_ff;
      comp_in     = comp_ff;
      qn_in       = qn_ff;
      pq_in       = pq_ff;
      mat_in      = mat_ff;

      // The bit length of the largest magnitude equals that of the OR of all four.
      mag_or = '0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = rot[i][QUAT_WIDTH-1] ? QUAT_WIDTH'(-rot[i]) : QUAT_WIDTH'(rot[i]);
         mag_or = mag_or | mag[i];
      end
      len = '0;
      for (int b = 0; b < QUAT_WIDTH; b++) begin
         if (mag_or[b]) len = LEN_WIDTH'(b + 1);
      end
      mag_ext = '0;

      sq_term = NSQ_WIDTH'(smag_ff[sq_cnt_ff]) * NSQ_WIDTH'(smag_ff[sq_cnt_ff]);

      rbit    = RACC_WIDTH'(1) << {root_cnt_ff, 1'b0};
      rsum    = root_ff + rbit;
      if (RACC_WIDTH'(rrem_ff) >= rsum) begin
         rrem_nx = NSQ_WIDTH'(RACC_WIDTH'(rrem_ff) - rsum);
         root_nx = (root_ff >> 1) + rbit;
      end else begin
         rrem_nx = rrem_ff;
         root_nx = root_ff >> 1;
      end

      dsub    = DIV_WIDTH'(nrm_ff) << div_bit_ff;
      dge     = drem_ff >= dsub;
      drem_nx = dge ? drem_ff - dsub : drem_ff;
      quo_nx  = dge ? (quo_ff | (QUAT_WIDTH'(1) << div_bit_ff)) : quo_ff;

      for (int k = 0; k < 10; k++) begin
         e[k] = SUM_WIDTH'(pq_ff[k]);
      end

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               neg_in[i] = rot[i][QUAT_WIDTH-1];
               mag_ext   = EXT_WIDTH'(mag[i]);
               if (len < SMAG_WIDTH) begin
                  smag_in[i] = SMAG_WIDTH'(mag_ext << (SMAG_WIDTH - len));
               end else begin
                  smag_in[i] = SMAG_WIDTH'(mag_ext >> (len - SMAG_WIDTH));
               end
            end
            if (mag_or == '0) begin
               for (int i = 0; i < 4; i++) qn_in[i] = '0;
               state_in = ST_PRODUCT;
            end else begin
               nsq_in    = '0;
               sq_cnt_in = '0;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            nsq_in    = nsq_ff + sq_term;
            sq_cnt_in = sq_cnt_ff + 2'd1;
            if (sq_cnt_ff == 2'd3) begin
               rrem_in     = nsq_ff + sq_term;
               root_in     = '0;
               root_cnt_in = RCNT_WIDTH'(ROOT_ITER - 1);
               state_in    = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rrem_in     = rrem_nx;
            root_in     = root_nx;
            root_cnt_in = root_cnt_ff - 1'b1;
            if (root_cnt_ff == '0) begin
               nrm_in     = ROOT_WIDTH'(root_nx);
               comp_in    = '0;
               div_bit_in = QBIT_WIDTH'(QFRAC);
               quo_in     = '0;
               drem_in    = div_init(smag_ff[0], ROOT_WIDTH'(root_nx));
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            drem_in    = drem_nx;
            quo_in     = quo_nx;
            div_bit_in = div_bit_ff - 1'b1;
            if (div_bit_ff == '0) begin
               qn_in[comp_ff] = neg_ff[comp_ff] ? quat_comp_type'(-quo_nx) : quat_comp_type'(quo_nx);
               if (comp_ff == 2'd3) begin
                  state_in = ST_PRODUCT;
               end else begin
                  comp_in    = comp_ff + 2'd1;
                  div_bit_in = QBIT_WIDTH'(QFRAC);
                  quo_in     = '0;
                  drem_in    = div_init(smag_ff[2'(comp_ff + 2'd1)], nrm_ff);
               end
            end
         end
         ST_PRODUCT: begin
            pq_in[0] = PQ_WIDTH'(qn_ff[0]) * PQ_WIDTH'(qn_ff[0]);
            pq_in[1] = PQ_WIDTH'(qn_ff[1]) * PQ_WIDTH'(qn_ff[1]);
            pq_in[2] = PQ_WIDTH'(qn_ff[2]) * PQ_WIDTH'(qn_ff[2]);
            pq_in[3] = PQ_WIDTH'(qn_ff[3]) * PQ_WIDTH'(qn_ff[3]);
            pq_in[4] = PQ_WIDTH'(qn_ff[0]) * PQ_WIDTH'(qn_ff[1]);
            pq_in[5] = PQ_WIDTH'(qn_ff[0]) * PQ_WIDTH'(qn_ff[2]);
            pq_in[6] = PQ_WIDTH'(qn_ff[1]) * PQ_WIDTH'(qn_ff[2]);
            pq_in[7] = PQ_WIDTH'(qn_ff[3]) * PQ_WIDTH'(qn_ff[0]);
            pq_in[8] = PQ_WIDTH'(qn_ff[3]) * PQ_WIDTH'(qn_ff[1]);
            pq_in[9] = PQ_WIDTH'(qn_ff[3]) * PQ_WIDTH'(qn_ff[2]);
            state_in = ST_MATRIX;
         end
         ST_MATRIX: begin
            // Products are xx, yy, zz, ww, xy, xz, yz, wx, wy, wz in that order.
            mat_in[0][0] = MAT_WIDTH'(e[3] + e[0] - e[1] - e[2]);
            mat_in[0][1] = MAT_WIDTH'((e[4] - e[9]) <<< 1);
            mat_in[0][2] = MAT_WIDTH'((e[5] + e[8]) <<< 1);
            mat_in[1][0] = MAT_WIDTH'((e[4] + e[9]) <<< 1);
            mat_in[1][1] = MAT_WIDTH'(e[3] - e[0] + e[1] - e[2]);
            mat_in[1][2] = MAT_WIDTH'((e[6] - e[7]) <<< 1);
            mat_in[2][0] = MAT_WIDTH'((e[5] - e[8]) <<< 1);
            mat_in[2][1] = MAT_WIDTH'((e[6] + e[7]) <<< 1);
            mat_in[2][2] = MAT_WIDTH'(e[3] - e[0] - e[1] + e[2]);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A fresh rotation write restarts the calculation from the top.
      if (start) state_in = ST_SCALE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               mat_ff[i][j] <= (i == j) ? mat_elem_type'(MAT_WIDTH'(1) << MAT_FRAC) : '0;
            end
         end
      end else begin
         state_ff <= state_in;
         mat_ff   <= mat_in;
      end
      neg_ff      <= neg_in;
      smag_ff     <= smag_in;
      sq_cnt_ff   <= sq_cnt_in;
      nsq_ff      <= nsq_in;
      rrem_ff     <= rrem_in;
      root_ff     <= root_in;
      root_cnt_ff <= root_cnt_in;
      nrm_ff      <= nrm_in;
      drem_ff     <= drem_in;
      quo_ff      <= quo_in;
      div_bit_ff  <= div_bit_in;
      comp_ff     <= comp_in;
      qn_ff       <= qn_in;
      pq_ff       <= pq_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign mat  = mat_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset) start |=> busy)
      else $error("normaliser not busy after a rotation write");

   a_nrm_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (nrm_ff != '0))
      else $error("division by a zero norm");

   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIVIDE) && (div_bit_ff == '0)) |-> (quo_nx <= (QUAT_WIDTH'(1) << QFRAC)))
      else $error("normalised component exceeds one");

endmodule

// ===== rtl/core/rigid_transform_point.sv =====
// Rigid transform of one Q16.16 point or vector per request.
// Requests arrive on req_valid/req_ready with req_data (command and three
// coordinates); results leave on rsp_valid/rsp_ready with rsp_data.
// The transform is held in seven registers written through csr_we,
// csr_index and csr_wdata: position x, y, z, then rotation x, y, z, w.
// The pipeline takes one request per clock while the normaliser is idle and
// the receiver keeps rsp_ready high; a request passes stages a, b and c to rsp_data.
// Every write to a rotation register starts the quaternion normaliser, which
// scales the components, sums their squares, takes a bit-serial square root,
// runs four 15-step divisions and forms the matrix from the products; an
// all-zero rotation skips to the products. req_ready is low while it runs.
// Reset loads the identity rotation and a zero position, with the matrix
// ready at once, and empties the pipeline.
// When the receiver holds rsp_ready low, the result is kept and the stages
// behind it keep filling; back-pressure lowers req_ready only once every stage is full.
module rigid_transform_point import rtp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   coord_type      pos_ff [3];
   quat_comp_type  rot_ff [4];
   logic           rot_start;
   logic           norm_busy;
   mat_elem_type   mat [3][3];

   logic                         a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   logic                         a_ready, b_ready, c_ready, d_ready;
   cmd_type                      a_cmd_ff, b_cmd_ff;
   logic signed [VEC_WIDTH-1:0]  a_vec_ff [3], a_vec_in [3];
   logic signed [PROD_WIDTH-1:0] b_prod_ff [3][3], b_prod_in [3][3];
   logic signed [ACC_WIDTH-1:0]  c_acc_ff [3], c_acc_in [3];
   rsp_type                      rsp_data_ff, rsp_data_in;
   coord_type                    coord [3];
   logic                         inverse;

   function automatic coord_type round_sat(input logic signed [ACC_WIDTH-1:0] a);
      logic signed [ACC_WIDTH-1:0] t;
      logic signed [SH_WIDTH-1:0]  s;
      t = a + (ACC_WIDTH'(1) << (MAT_FRAC - 1));
      s = t[ACC_WIDTH-1:MAT_FRAC];
      if (s > SH_WIDTH'(COORD_MAX)) return COORD_MAX;
      if (s < SH_WIDTH'(COORD_MIN)) return COORD_MIN;
      return s[COORD_WIDTH-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) pos_ff[i] <= '0;
         rot_ff[0] <= '0;
         rot_ff[1] <= '0;
         rot_ff[2] <= '0;
         rot_ff[3] <= quat_comp_type'(QUAT_WIDTH'(1) << QFRAC);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POS_X: pos_ff[0] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_POS_Y: pos_ff[1] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_POS_Z: pos_ff[2] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_ROT_X: rot_ff[0] <= csr_wdata[QUAT_WIDTH-1:0];
            CSR_ROT_Y: rot_ff[1] <= csr_wdata[QUAT_WIDTH-1:0];
            CSR_ROT_Z: rot_ff[2] <= csr_wdata[QUAT_WIDTH-1:0];
            CSR_ROT_W: rot_ff[3] <= csr_wdata[QUAT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rot_start = csr_we && ((csr_index == CSR_ROT_X) || (csr_index == CSR_ROT_Y) ||
                                 (csr_index == CSR_ROT_Z) || (csr_index == CSR_ROT_W));

   rtp_quat_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (rot_start),
      .rot   (rot_ff),
      .busy  (norm_busy),
      .mat   (mat)
   );

   // A stage may load when it is empty or its content moves on in this cycle.
   assign d_ready   = !rsp_valid_ff || rsp_ready;
   assign c_ready   = !c_valid_ff || d_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_ready = a_ready && !norm_busy;

   assign coord[0] = req_data.coord_x;
   assign coord[1] = req_data.coord_y;
   assign coord[2] = req_data.coord_z;
   assign inverse  = (a_cmd_ff == CMD_INV_POINT) || (a_cmd_ff == CMD_INV_VECTOR);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (req_data.command == CMD_INV_POINT) begin
            a_vec_in[i] = VEC_WIDTH'(coord[i]) - VEC_WIDTH'(pos_ff[i]);
         end else begin
            a_vec_in[i] = VEC_WIDTH'(coord[i]);
         end
      end
      // The inverse commands rotate by the transposed matrix.
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            b_prod_in[i][j] = (inverse ? mat[j][i] : mat[i][j]) * a_vec_ff[j];
         end
      end
      for (int i = 0; i < 3; i++) begin
         c_acc_in[i] = ACC_WIDTH'(b_prod_ff[i][0]) + ACC_WIDTH'(b_prod_ff[i][1]) +
                       ACC_WIDTH'(b_prod_ff[i][2]);
         if (b_cmd_ff == CMD_POINT) begin
            c_acc_in[i] = c_acc_in[i] + (ACC_WIDTH'(pos_ff[i]) <<< MAT_FRAC);
         end
      end
      rsp_data_in.out_x = round_sat(c_acc_ff[0]);
      rsp_data_in.out_y = round_sat(c_acc_ff[1]);
      rsp_data_in.out_z = round_sat(c_acc_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= req_valid && !norm_busy;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (d_ready) rsp_valid_ff <= c_valid_ff;
      end
      if (a_ready) begin
         a_cmd_ff <= req_data.command;
         a_vec_ff <= a_vec_in;
      end
      if (b_ready) begin
         b_cmd_ff  <= a_cmd_ff;
         b_prod_ff <= b_prod_in;
      end
      if (c_ready) c_acc_ff <= c_acc_in;
      if (d_ready) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rot_blocks: assert property (@(posedge clock) disable iff (reset) rot_start |=> !req_ready)
      else $error("request taken while the matrix is being rebuilt");

   a_stage_ab: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && b_ready) |=> b_valid_ff)
      else $error("request lost between first and second stage");

   a_stage_cd: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && d_ready) |=> rsp_valid)
      else $error("request lost before the output register");

endmodule

// ===== tb/tb_rigid_transform_point.sv =====
`timescale 1ns / 100ps

module tb_rigid_transform_point;
   import rtp_pkg::*;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 8;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_data;
   logic                      csr_we;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   // Shadow copy of the transform registers.
   coord_type     shadow_pos[3];
   quat_comp_type shadow_rot[4];

   rsp_type expected_points[$];
   int      mismatches;
   int      requests_sent;
   int      results_checked;
   int      csr_writes;
   bit      steady;

   rigid_transform_point u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_rigid_transform_point NOT OK");
      $finish;
   end

   function automatic coord_type saturate_round(logic signed [127:0] acc);
      logic signed [127:0] r;
      r = (acc + (128'sd1 <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
      if (r > 128'sd2147483647) return 32'sh7fffffff;
      if (r < -128'sd2147483648) return 32'sh80000000;
      return r[31:0];
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      logic [63:0]         mag[4];
      logic [63:0]         mx, n2, nrm, bitv;
      longint              qn[4];
      longint              x, y, z, w;
      longint              m[3][3];
      int                  len;
      logic signed [127:0] v[3], acc, c;
      coord_type           res[3];
      rsp_type             o;
      mx = 0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = shadow_rot[i] < 0 ? 64'(-longint'(shadow_rot[i])) : 64'(shadow_rot[i]);
         if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 4; i++) qn[i] = 0;
      end else begin
         len = 0;
         while ((mx >> len) != 0) len++;
         n2 = 0;
         for (int i = 0; i < 4; i++) begin
            mag[i] = len < 30 ? mag[i] << (30 - len) : mag[i] >> (len - 30);
            n2 += mag[i] * mag[i];
         end
         nrm = 0;
         bitv = 64'd1 << 62;
         while (bitv > n2) bitv >>= 2;
         while (bitv != 0) begin
            if (n2 >= nrm + bitv) begin
               n2 -= nrm + bitv;
               nrm = (nrm >> 1) + bitv;
            end else begin
               nrm >>= 1;
            end
            bitv >>= 2;
         end
         for (int i = 0; i < 4; i++) begin
            qn[i] = longint'(((mag[i] << QFRAC) + nrm / 2) / nrm);
            if (shadow_rot[i] < 0) qn[i] = -qn[i];
         end
      end
      x = qn[0]; y = qn[1]; z = qn[2]; w = qn[3];
      m[0][0] = w*w + x*x - y*y - z*z; m[0][1] = 2*(x*y - w*z); m[0][2] = 2*(x*z + w*y);
      m[1][0] = 2*(x*y + w*z); m[1][1] = w*w - x*x + y*y - z*z; m[1][2] = 2*(y*z - w*x);
      m[2][0] = 2*(x*z - w*y); m[2][1] = 2*(y*z + w*x); m[2][2] = w*w - x*x - y*y + z*z;
      v[0] = r.coord_x; v[1] = r.coord_y; v[2] = r.coord_z;
      if (r.command == CMD_INV_POINT)
         for (int i = 0; i < 3; i++) v[i] -= shadow_pos[i];
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            // Inverse commands rotate by the conjugate, i.e. the transposed matrix.
            c = (r.command == CMD_INV_POINT || r.command == CMD_INV_VECTOR) ? m[j][i] : m[i][j];
            acc += c * v[j];
         end
         if (r.command == CMD_POINT) acc += 128'(shadow_pos[i]) <<< MAT_FRAC;
         res[i] = saturate_round(acc);
      end
      o.out_x = res[0]; o.out_y = res[1]; o.out_z = res[2];
      return o;
   endfunction

   task automatic send_request(cmd_type cmd, coord_type cx, coord_type cy, coord_type cz);
      req_type r;
      r.command = cmd; r.coord_x = cx; r.coord_y = cy; r.coord_z = cz;
      if (!steady && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expected_points.push_back(predict_rsp(r));
      requests_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_POS_X, CSR_POS_Y, CSR_POS_Z: shadow_pos[2'(idx)] = val;
         CSR_ROT_X, CSR_ROT_Y, CSR_ROT_Z, CSR_ROT_W: shadow_rot[2'(idx - CSR_ROT_X)] = val[15:0];
         default: ;
      endcase
   endtask

   task automatic load_transform(coord_type px, coord_type py, coord_type pz,
                                 quat_comp_type rx, quat_comp_type ry,
                                 quat_comp_type rz, quat_comp_type rw);
      drain();
      write_csr(CSR_POS_X, px);
      write_csr(CSR_POS_Y, py);
      write_csr(CSR_POS_Z, pz);
      write_csr(CSR_ROT_X, CSR_DATA_WIDTH'(rx));
      write_csr(CSR_ROT_Y, CSR_DATA_WIDTH'(ry));
      write_csr(CSR_ROT_Z, CSR_DATA_WIDTH'(rz));
      write_csr(CSR_ROT_W, CSR_DATA_WIDTH'(rw));
   endtask

   function automatic coord_type random_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h7ff)) - 32'sh400;
         default: return $signed($urandom_range(0, 32'h1fffffff)) - 32'sh10000000;
      endcase
   endfunction

   function automatic quat_comp_type random_rot();
      case ($urandom_range(4))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'(int'($urandom_range(0, 6)) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_all_commands(coord_type cx, coord_type cy, coord_type cz);
      send_request(CMD_POINT, cx, cy, cz);
      send_request(CMD_VECTOR, cx, cy, cz);
      send_request(CMD_INV_POINT, cx, cy, cz);
      send_request(CMD_INV_VECTOR, cx, cy, cz);
   endtask

   // Identity rotation from reset, with extremes of the coordinate range.
   task automatic test_reset_identity;
      send_all_commands(32'sh7fffffff, 32'sh80000000, 32'sh0);
      send_request(CMD_POINT, 32'sh1, -32'sh1, 32'sh10000);
   endtask

   // A rotation with large components and a position at both ends of its range.
   task automatic test_extreme_transform;
      load_transform(32'sh7fffffff, 32'sh80000000, 32'sh12345, 16'sh7fff, 16'sh0, 16'sh0, 16'sh7fff);
      send_all_commands(32'sh7fffffff, 32'sh80000000, 32'shffffffff);
      send_all_commands(32'sh10000, 32'sh20000, -32'sh30000);
   endtask

   // An all-zero quaternion leaves only the position term.
   task automatic test_zero_quaternion;
      load_transform(32'sh50000, -32'sh70000, 32'sh1, 16'sh0, 16'sh0, 16'sh0, 16'sh0);
      send_all_commands(32'sh7fffffff, 32'sh12345678, 32'sh80000000);
   endtask

   // The most negative value in every component is normalised as usual.
   task automatic test_most_negative_rotation;
      load_transform(32'sh80000000, 32'sh80000000, 32'sh80000000,
                     16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_all_commands(32'sh7fffffff, -32'sh1, 32'sh40000);
   endtask

   // A write to an unused index must not disturb the transform.
   task automatic test_unused_index;
      drain();
      write_csr(CSR_UNUSED, 32'hdeadbeef);
      send_all_commands(32'sh1000, 32'sh2000, 32'sh3000);
   endtask

   task automatic test_random_traffic;
      int phase;
      for (phase = 0; phase < 30; phase++) begin
         load_transform(random_coord(), random_coord(), random_coord(),
                        random_rot(), random_rot(), random_rot(), random_rot());
         steady = (phase == 12);
         repeat (62) send_request(cmd_type'($urandom_range(3)), random_coord(),
                                  random_coord(), random_coord());
         steady = 1'b0;
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = expected_points.pop_front();
            results_checked++;
            if (rsp_data.out_x !== want.out_x || rsp_data.out_y !== want.out_y ||
                rsp_data.out_z !== want.out_z) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                           want.out_x, want.out_y, want.out_z,
                           rsp_data.out_x, rsp_data.out_y, rsp_data.out_z);
            end
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      steady          = 1'b0;
      mismatches      = 0;
      requests_sent   = 0;
      results_checked = 0;
      csr_writes      = 0;
      shadow_pos = '{default: '0};
      shadow_rot = '{16'sh0, 16'sh0, 16'sh0, 16'sh4000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_identity();
      test_extreme_transform();
      test_zero_quaternion();
      test_most_negative_rotation();
      test_unused_index();
      test_random_traffic();
      if (expected_points.size() != 0) mismatches += expected_points.size();
      $display("Sent %0d requests across all four commands, checked %0d results,",
               requests_sent, results_checked);
      $display("with %0d register writes and %0d mismatches.", csr_writes, mismatches);
      if (mismatches == 0) begin
         $display("tb_rigid_transform_point OK");
      end else begin
         $display("tb_rigid_transform_point NOT OK");
      end
      $finish;
   end

endmodule
